// ===== hw/rtl/tvt_pkg.sv =====
// Shared types, sizes and operation codes for the tagged value table.
package tvt_pkg;

  // Slots including the terminator slot, and the entries that can be held.
  localparam int MAX_SLOTS = 64;
  localparam int N_ENTRIES = MAX_SLOTS - 1;

  // Width of an entry index or of the entry count.
  localparam int CNT_W = $clog2(MAX_SLOTS);

  // Width used for capacity arithmetic: wide enough for the register and for MAX_SLOTS.
  localparam int CAP_W = (CNT_W + 1 > 7) ? CNT_W + 1 : 7;

  // Fixed field widths of the ports.
  localparam int KIND_W   = 2;
  localparam int TAG_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int CAPREG_W = 7;
  localparam int COUNT_W  = 6;

  // Operation codes carried in the kind field.
  typedef enum logic [KIND_W-1:0] {
    KIND_SEARCH = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2
  } kind_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  // Probe that travels along the row of cells, one cell per cycle.
  typedef struct packed {
    logic               vld;
    logic [TAG_W-1:0]   tag;
    logic               hit;
    logic [CNT_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
  } probe_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic               wr;
    logic               shift;
    logic [CNT_W-1:0]   pos;
    logic [TAG_W-1:0]   tag;
    logic [VALUE_W-1:0] value;
  } upd_t;

endpackage

// ===== hw/rtl/tvt_cell.sv =====
// One slot of the table: holds a tag and value and passes the search probe on.
module tvt_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tvt_pkg::CNT_W-1:0]   idx,
  input  logic [tvt_pkg::CNT_W-1:0]   held,
  input  tvt_pkg::probe_t             probe_i,
  output tvt_pkg::probe_t             probe_o,
  input  tvt_pkg::upd_t               upd,
  input  logic [tvt_pkg::TAG_W-1:0]   nb_tag,
  input  logic [tvt_pkg::VALUE_W-1:0] nb_value,
  output logic [tvt_pkg::TAG_W-1:0]   tag_o,
  output logic [tvt_pkg::VALUE_W-1:0] value_o
);
  import tvt_pkg::*;

  logic [TAG_W-1:0]   tag_r;
  logic [VALUE_W-1:0] value_r;
  probe_t             probe_r;
  probe_t             probe_nxt;
  logic               match;

  // A live slot whose tag equals the probe tag claims the first hit.
  always_comb begin
    match     = probe_i.vld && !probe_i.hit && (idx < held) && (tag_r == probe_i.tag);
    probe_nxt = probe_i;
    if (match) begin
      probe_nxt.hit   = 1'b1;
      probe_nxt.pos   = idx;
      probe_nxt.value = value_r;
    end
  end

  // Probe stage register: only the valid flag needs a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.vld <= 1'b0;
    end else begin
      probe_r.vld <= probe_nxt.vld;
    end
    probe_r.tag   <= probe_nxt.tag;
    probe_r.hit   <= probe_nxt.hit;
    probe_r.pos   <= probe_nxt.pos;
    probe_r.value <= probe_nxt.value;
  end

  // Slot contents: written on insert, or taken from the next slot on delete.
  always_ff @(posedge clk) begin
    if (upd.wr && (idx == upd.pos)) begin
      tag_r   <= upd.tag;
      value_r <= upd.value;
    end else if (upd.shift && (idx >= upd.pos)) begin
      tag_r   <= nb_tag;
      value_r <= nb_value;
    end
  end

  assign probe_o = probe_r;
  assign tag_o   = tag_r;
  assign value_o = value_r;

endmodule

// ===== hw/rtl/tagged_value_table_top.sv =====
// Top level of the tagged value table: controller, capacity register and row of cells.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | in_kind, in_tag, in_entry_value
//   out_    | output    | out_valid/out_stall | out_ok, out_found_value, out_entry_count
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_data (capacity)
//
// Each transaction goes through these steps from acceptance to result: the search probe
// enters the first of the MAX_SLOTS - 1 cells at the accepting edge and moves on one
// cell a cycle, what it found is then registered, and after that the insert or delete
// is committed and the output register is loaded.
// One transaction is worked on at a time; the next is accepted once the previous
// one has been committed, even while its result still waits in the output register.
// A stalled result holds the commit of the following transaction back.
// Reset empties the table and sets the capacity to 64; no clearing pass is needed.
module tagged_value_table_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tvt_pkg::KIND_W-1:0]     in_kind,
  input  logic [tvt_pkg::TAG_W-1:0]      in_tag,
  input  logic [tvt_pkg::VALUE_W-1:0]    in_entry_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_ok,
  output logic [tvt_pkg::VALUE_W-1:0]    out_found_value,
  output logic [tvt_pkg::COUNT_W-1:0]    out_entry_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tvt_pkg::CAPREG_W-1:0]   cfg_data
);
  import tvt_pkg::*;

  state_t               state_r;
  state_t               state_nxt;
  logic [CAPREG_W-1:0]  cap_r;
  logic [CNT_W-1:0]     held_r;
  logic [CNT_W-1:0]     held_nxt;
  logic [KIND_W-1:0]    kind_r;
  logic [TAG_W-1:0]     tag_r;
  logic [VALUE_W-1:0]   val_r;
  logic                 hit_r;
  logic [CNT_W-1:0]     pos_r;
  logic [VALUE_W-1:0]   fval_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 out_ok_r;
  logic [VALUE_W-1:0]   out_fv_r;
  logic [COUNT_W-1:0]   out_cnt_r;
  logic                 ok_w;
  logic [VALUE_W-1:0]   fv_w;
  logic                 in_fire;
  logic                 commit;
  logic                 ins_ok;
  logic [CAP_W-1:0]     eff_cap;
  upd_t                 upd;

  probe_t               probe_w [0:N_ENTRIES];
  logic [TAG_W-1:0]     tags_w  [0:N_ENTRIES-1];
  logic [VALUE_W-1:0]   vals_w  [0:N_ENTRIES-1];

  // Neither the input nor the capacity port takes a transaction during reset.
  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign cfg_ready = rst_n;

  // Capacity saturates at the number of slots that exist.
  assign eff_cap = (CAP_W'(cap_r) > CAP_W'(MAX_SLOTS)) ? CAP_W'(MAX_SLOTS) : CAP_W'(cap_r);

  // Insert needs a fresh nonzero tag and room below the terminator.
  assign ins_ok = (tag_r != '0) && !hit_r &&
                  ((CAP_W'(held_r) + CAP_W'(1)) < eff_cap) &&
                  (held_r != CNT_W'(N_ENTRIES));

  // Probe injected into the first cell when a transaction is accepted.
  always_comb begin
    probe_w[0].vld   = in_fire;
    probe_w[0].tag   = in_tag;
    probe_w[0].hit   = 1'b0;
    probe_w[0].pos   = '0;
    probe_w[0].value = '0;
  end

  // Row of cells; the last one has no right-hand neighbour.
  for (genvar i = 0; i < N_ENTRIES; i++) begin : g_cell
    logic [TAG_W-1:0]   nb_tag;
    logic [VALUE_W-1:0] nb_value;
    if (i == N_ENTRIES - 1) begin : g_last
      assign nb_tag   = '0;
      assign nb_value = '0;
    end else begin : g_mid
      assign nb_tag   = tags_w[i+1];
      assign nb_value = vals_w[i+1];
    end
    tvt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (CNT_W'(i)),
      .held     (held_r),
      .probe_i  (probe_w[i]),
      .probe_o  (probe_w[i+1]),
      .upd      (upd),
      .nb_tag   (nb_tag),
      .nb_value (nb_value),
      .tag_o    (tags_w[i]),
      .value_o  (vals_w[i])
    );
  end

  // Next state, commit decision, result and table update.
  always_comb begin
    state_nxt     = state_r;
    commit        = 1'b0;
    held_nxt      = held_r;
    ok_w          = 1'b0;
    fv_w          = '0;
    upd.wr        = 1'b0;
    upd.shift     = 1'b0;
    upd.pos       = pos_r;
    upd.tag       = tag_r;
    upd.value     = val_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (probe_w[N_ENTRIES].vld) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          commit        = 1'b1;
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          case (kind_r)
            KIND_SEARCH: begin
              if (tag_r == '0) begin
                ok_w = 1'b1;
                fv_w = VALUE_W'(eff_cap);
              end else begin
                ok_w = hit_r;
                fv_w = hit_r ? fval_r : '0;
              end
            end
            KIND_INSERT: begin
              ok_w    = ins_ok;
              upd.wr  = ins_ok;
              upd.pos = held_r;
              if (ins_ok) begin
                held_nxt = held_r + CNT_W'(1);
              end
            end
            KIND_DELETE: begin
              if (tag_r == '0) begin
                ok_w = 1'b1;
              end else if (hit_r) begin
                ok_w      = 1'b1;
                upd.shift = 1'b1;
                held_nxt  = held_r - CNT_W'(1);
              end
            end
            default: begin
              ok_w = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      cap_r       <= CAPREG_W'(64);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Transaction payload, probe result and output registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_kind;
      tag_r  <= in_tag;
      val_r  <= in_entry_value;
    end
    if (state_r == S_SCAN && probe_w[N_ENTRIES].vld) begin
      hit_r  <= probe_w[N_ENTRIES].hit;
      pos_r  <= probe_w[N_ENTRIES].pos;
      fval_r <= probe_w[N_ENTRIES].value;
    end
    if (commit) begin
      out_ok_r  <= ok_w;
      out_fv_r  <= fv_w;
      out_cnt_r <= COUNT_W'(held_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_found_value = out_fv_r;
  assign out_entry_count = out_cnt_r;

  // The entry count never exceeds the number of cells.
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(N_ENTRIES))
    else $error("entry count beyond the number of cells");

  // An accepted transaction starts the scan on the next cycle.
  a_fire_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_SCAN)
    else $error("accepted transaction did not start a scan");

  // A commit always leaves a result in the output register.
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("commit without a result");

  // The probe only leaves the row while the controller is scanning.
  a_probe_scan: assert property (@(posedge clk) disable iff (!rst_n)
    probe_w[N_ENTRIES].vld |-> state_r == S_SCAN)
    else $error("probe left the row outside a scan");

endmodule

// ===== tb/sv/tb_tagged_value_table_top.sv =====
// Self-checking testbench for the tagged value table: directed and random operations.
module tb_tagged_value_table_top;
  import tvt_pkg::*;

  // Cycles without any transaction before the run is abandoned.
  localparam int IDLE_LIMIT = 3000;
  // Length of the one long hold-off on the result side.
  localparam int LONG_HOLD  = 400;
  // Cycles allowed after the last expected result before the final verdict.
  localparam int DRAIN_WAIT = 80;
  localparam int POOL_SIZE  = 80;

  // One expected result of the table.
  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] found_value;
    logic [COUNT_W-1:0] entry_count;
  } reply_t;

  // Scoreboard: keeps its own copy of the table and the capacity, and
  // queues the reply that each accepted operation should produce.
  class tvt_scoreboard;
    logic [TAG_W-1:0]   tags   [0:N_ENTRIES-1];
    logic [VALUE_W-1:0] values [0:N_ENTRIES-1];
    int     held;
    int     capacity;
    reply_t pending_replies [$];
    int     errors;
    int     n_kind [3];
    int     n_ok;
    int     n_full;
    int     n_cfg;
    int     peak;

    function new();
      held     = 0;
      capacity = MAX_SLOTS;
      errors   = 0;
      n_ok     = 0;
      n_full   = 0;
      n_cfg    = 0;
      peak     = 0;
      foreach (n_kind[i]) n_kind[i] = 0;
    endfunction

    // Prints one line per mismatch and counts it.
    task report(input string what, input longint expv, input longint got);
      errors++;
      $display("MISMATCH %s: expected %0h, got %0h", what, expv, got);
    endtask

    function void set_capacity(input logic [CAPREG_W-1:0] c);
      capacity = (c > MAX_SLOTS) ? MAX_SLOTS : int'(c);
      n_cfg++;
    endfunction

    // Position of a tag among the held entries, or held if it is absent.
    function int locate(input logic [TAG_W-1:0] t);
      for (int i = 0; i < held; i++)
        if (tags[i] == t) return i;
      return held;
    endfunction

    // Applies one accepted operation to the local table and queues its reply.
    function void note_request(input kind_t k, input logic [TAG_W-1:0] t,
                               input logic [VALUE_W-1:0] v);
      reply_t r;
      int     pos;
      r = '0;
      case (k)
        KIND_SEARCH: begin
          if (t == '0) begin
            r.ok          = 1'b1;
            r.found_value = VALUE_W'(capacity);
          end else begin
            pos = locate(t);
            if (pos < held) begin
              r.ok          = 1'b1;
              r.found_value = values[pos];
            end
          end
        end
        KIND_INSERT: begin
          if (t != '0 && locate(t) == held && held + 1 < capacity && held < N_ENTRIES) begin
            tags[held]   = t;
            values[held] = v;
            held++;
            r.ok = 1'b1;
          end else if (t != '0 && locate(t) == held) begin
            n_full++;
          end
        end
        KIND_DELETE: begin
          if (t == '0) begin
            r.ok = 1'b1;
          end else begin
            pos = locate(t);
            if (pos < held) begin
              for (int i = pos; i + 1 < held; i++) begin
                tags[i]   = tags[i + 1];
                values[i] = values[i + 1];
              end
              held--;
              r.ok = 1'b1;
            end
          end
        end
        default: ;
      endcase
      r.entry_count = COUNT_W'(held);
      if (held > peak) peak = held;
      if (int'(k) < 3) n_kind[int'(k)]++;
      if (r.ok) n_ok++;
      pending_replies.push_back(r);
    endfunction

    // Compares one accepted result with the oldest queued reply.
    task check_reply(input logic ok, input logic [VALUE_W-1:0] fv,
                     input logic [COUNT_W-1:0] cnt);
      reply_t e;
      if (pending_replies.size() == 0) begin
        report("result with nothing outstanding", 0, 1);
      end else begin
        e = pending_replies.pop_front();
        if (ok !== e.ok)           report("ok", e.ok, ok);
        if (fv !== e.found_value)  report("found_value", e.found_value, fv);
        if (cnt !== e.entry_count) report("entry_count", e.entry_count, cnt);
      end
    endtask

    task close_out();
      if (pending_replies.size() != 0)
        report("results never delivered", pending_replies.size(), 0);
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind;
  logic [TAG_W-1:0]    in_tag;
  logic [VALUE_W-1:0]  in_entry_value;
  logic                out_valid;
  logic                out_stall;
  logic                out_ok;
  logic [VALUE_W-1:0]  out_found_value;
  logic [COUNT_W-1:0]  out_entry_count;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CAPREG_W-1:0] cfg_data;

  tvt_scoreboard sb;

  // Shared control between the sender and the result-side process.
  bit quiet       = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_served = 1'b0;

  logic [TAG_W-1:0] tag_pool [0:POOL_SIZE-1];
  int               pool_span;
  int               idle_cycles = 0;

  tagged_value_table_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_tag          (in_tag),
    .in_entry_value  (in_entry_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_found_value (out_found_value),
    .out_entry_count (out_entry_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #2 clk = ~clk;

  // Monitor: results are checked before the same edge's operation is noted.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_valid && !out_stall)
        sb.check_reply(out_ok, out_found_value, out_entry_count);
      if (in_valid && !in_stall)
        sb.note_request(kind_t'(in_kind), in_tag, in_entry_value);
      if (cfg_valid && cfg_ready)
        sb.set_capacity(cfg_data);
    end
  end

  // Watchdog on cycles in which no transaction of any kind completes.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_stall   = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Offers one operation, sometimes after an idle burst, and
  // returns once it has been accepted.
  task send_op(input kind_t k, input logic [TAG_W-1:0] t, input logic [VALUE_W-1:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_kind        = k;
    in_tag         = t;
    in_entry_value = v;
    do @(posedge clk); while (in_stall);
  endtask

  // Mostly tags from the pool so that searches and deletes hit, with some
  // fresh random tags and the terminator now and then.
  function automatic logic [TAG_W-1:0] pick_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)  return '0;
    if (r < 10) return $urandom;
    return tag_pool[$urandom_range(0, pool_span - 1)];
  endfunction

  task run_mix(input int count, input int ins_pct, input int del_pct);
    int    r;
    kind_t k;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct)                k = KIND_INSERT;
      else if (r < ins_pct + del_pct) k = KIND_DELETE;
      else                            k = KIND_SEARCH;
      send_op(k, pick_tag(), $urandom);
    end
  endtask

  // Lets the table go idle, then writes a new capacity.
  task new_phase(input int cap, input int span);
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = CAPREG_W'(cap);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    pool_span = (span > POOL_SIZE) ? POOL_SIZE : span;
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_SEARCH;
    in_tag         = '0;
    in_entry_value = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    pool_span      = 24;

    // Tag pool, with the extreme patterns at the front.
    tag_pool[0] = 32'hFFFF_FFFF;
    tag_pool[1] = 32'h0000_0001;
    tag_pool[2] = 32'h8000_0000;
    for (int i = 3; i < POOL_SIZE; i++) begin
      tag_pool[i] = $urandom;
      if (tag_pool[i] == '0) tag_pool[i] = 32'h5A5A_A5A5;
    end

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset capacity: terminator handling, misses,
    // duplicates and deletes that shift later entries down.
    send_op(KIND_SEARCH, 32'h0, 32'h0);
    send_op(KIND_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(KIND_DELETE, 32'h0, 32'h0);
    send_op(KIND_DELETE, 32'h1234_5678, 32'h0);
    send_op(KIND_INSERT, 32'h0, 32'hDEAD_BEEF);
    send_op(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_op(KIND_INSERT, 32'h0000_0001, 32'h0);
    send_op(KIND_INSERT, 32'h8000_0000, 32'h1234_5678);
    send_op(KIND_INSERT, 32'h0000_0001, 32'h7777_7777);
    send_op(KIND_SEARCH, 32'hFFFF_FFFF, 32'h0);
    send_op(KIND_SEARCH, 32'h0000_0001, 32'h0);
    send_op(KIND_SEARCH, 32'h8000_0000, 32'h0);
    send_op(KIND_DELETE, 32'h0000_0001, 32'h0);
    send_op(KIND_SEARCH, 32'h8000_0000, 32'h0);
    send_op(KIND_DELETE, 32'hFFFF_FFFF, 32'h0);
    send_op(KIND_SEARCH, 32'hFFFF_FFFF, 32'h0);

    // Fill the table at full capacity, with one long hold on the result side.
    new_phase(MAX_SLOTS, 66);
    hold_req = 1'b1;
    run_mix(320, 65, 10);

    // Capacity lowered below the entry count: entries stay, inserts fail.
    new_phase(3, 72);
    run_mix(160, 25, 60);

    // Capacity of one: only the terminator fits.
    new_phase(1, 16);
    send_op(KIND_INSERT, 32'hA5A5_5A5A, 32'h0F0F_F0F0);
    send_op(KIND_SEARCH, 32'h0, 32'h0);
    run_mix(50, 40, 30);

    // Capacity of two: a single entry at most.
    new_phase(2, 16);
    run_mix(70, 40, 30);

    new_phase($urandom_range(1, MAX_SLOTS), 40);
    run_mix(220, 40, 25);

    // Back to full capacity; the last stretch runs with no idling at all.
    new_phase(MAX_SLOTS, 72);
    run_mix(130, 40, 25);
    quiet = 1'b1;
    run_mix(200, 40, 25);

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    sb.close_out();

    $display("Run covered %0d searches, %0d inserts, %0d deletes; %0d succeeded.",
             sb.n_kind[0], sb.n_kind[1], sb.n_kind[2], sb.n_ok);
    $display("Capacity written %0d times; peak entry count %0d; %0d inserts refused for room.",
             sb.n_cfg, sb.peak, sb.n_full);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
